FILE: sv/refpack_decompressor_macros.svh
// Assertion macros shared by the decompressor RTL.
`ifndef REFPACK_DECOMPRESSOR_MACROS_SVH
`define REFPACK_DECOMPRESSOR_MACROS_SVH
`ifndef SYNTHESIS
`define RPD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("refpack decompressor assertion failed");
`define RPD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("refpack decompressor assertion failed");
`else
`define RPD_ASSERT_IMP(label, ante, cons)
`define RPD_ASSERT_NXT(label, ante, cons)
`endif
`endif

FILE: sv/refpd_pkg.sv
`default_nettype none
package refpd_pkg;
    localparam int WINDOW_SIZE_DEF = 131072;
    localparam int CHUNK_BYTES_DEF = 32;
    localparam int CHUNK_MAX = 32;
    localparam int CHUNK_CW = 6;
    localparam logic [7:0] MAGIC_BYTE = 8'hFB;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;
    localparam logic [1:0] ST_LIMIT = 2'd3;

    typedef enum logic [2:0] {
        PH_FLAGS, PH_MAGIC, PH_SIZE, PH_CMD, PH_LIT, PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        S_IN, S_LIT, S_CPRD, S_CPWR, S_EMIT
    } state_t;

    typedef struct packed {
        logic       push;
        logic [7:0] push_byte;
        logic       emit;
        logic       last;
        logic       done;
        logic [1:0] status;
    } chunk_ctl_t;
endpackage
`default_nettype wire

FILE: sv/refpd_hist_ram.sv
`default_nettype none
module refpd_hist_ram #(
    parameter int AW = 17
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);
    logic [7:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: sv/refpd_chunker.sv
`default_nettype none
module refpd_chunker #(
    parameter int CHUNK = refpd_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire refpd_pkg::chunk_ctl_t ctl,
    output logic                       free,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // out_bytes_a, out_bytes_b, out_bytes_c, out_bytes_d, byte_count, two zero bits
    output logic [263:0]               m_tdata,
    output logic                       m_tlast,
    // stream_done, status
    output logic [2:0]                 m_tuser
);
    localparam int NB = refpd_pkg::CHUNK_MAX;
    localparam int IW = $clog2(NB);

    logic [NB*8-1:0]                 acc_reg;
    logic [refpd_pkg::CHUNK_CW-1:0]  cnt_reg;
    logic                            valid_reg;
    logic [NB*8-1:0]                 obytes_reg;
    logic [refpd_pkg::CHUNK_CW-1:0]  ocnt_reg;
    logic                            olast_reg;
    logic [2:0]                      ouser_reg;

    assign free = !valid_reg || m_tready;
    assign m_tvalid = valid_reg;
    assign m_tdata = {2'b00, ocnt_reg, obytes_reg};
    assign m_tlast = olast_reg;
    assign m_tuser = ouser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg <= '0;
            acc_reg <= '0;
        end else begin
            if (ctl.emit) begin
                valid_reg <= 1'b1;
                obytes_reg <= acc_reg;
                ocnt_reg <= cnt_reg;
                olast_reg <= ctl.last;
                ouser_reg <= {ctl.status, ctl.done};
                acc_reg <= '0;
                cnt_reg <= '0;
            end else begin
                if (m_tready) begin
                    valid_reg <= 1'b0;
                end
                if (ctl.push && cnt_reg < refpd_pkg::CHUNK_CW'(CHUNK)) begin
                    acc_reg[cnt_reg[IW-1:0]*8 +: 8] <= ctl.push_byte;
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

FILE: sv/refpack_decompressor.sv
// Header and command bytes are taken one per transfer.
// A literal goes through its transfer, a history write and a chunk hand-over.
// Each copied byte takes a history read, then a write; each chunk adds a hand-over.
// A literal's chunk reaches the output via S_LIT and S_EMIT, an empty result via S_EMIT alone, once the output is free.
// Synchronous active-low reset clears the parser; the history needs no clearing pass.
`default_nettype none
`include "refpack_decompressor_macros.svh"
module refpack_decompressor #(
    parameter int WINDOW_SIZE = refpd_pkg::WINDOW_SIZE_DEF,
    parameter int CHUNK_BYTES = refpd_pkg::CHUNK_BYTES_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // in_byte
    input  wire logic [7:0]   s_tdata,
    input  wire logic         s_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // out_bytes_a, out_bytes_b, out_bytes_c, out_bytes_d, byte_count, two zero bits
    output logic [263:0]      m_tdata,
    output logic              m_tlast,
    // stream_done, status
    output logic [2:0]        m_tuser
);
    localparam int AW = $clog2(WINDOW_SIZE);
    localparam int CHUNK = (CHUNK_BYTES > refpd_pkg::CHUNK_MAX) ? refpd_pkg::CHUNK_MAX
                                                                 : CHUNK_BYTES;

    refpd_pkg::state_t state_reg, state_next;
    refpd_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  hflags_reg, hflags_next;
    logic [3:0]  hrem_reg, hrem_next;
    logic [7:0]  cb0_reg, cb0_next, cb1_reg, cb1_next, cb2_reg, cb2_next;
    logic [1:0]  ci_reg, ci_next;
    logic [6:0]  ll_reg, ll_next;
    logic [31:0] exp_reg, exp_next;
    logic [31:0] oc_reg, oc_next;
    logic        fin_reg, fin_next;
    logic [10:0] pl_reg, pl_next;
    logic [17:0] po_reg, po_next;
    logic        endp_reg, endp_next;
    logic [7:0]  litb_reg, litb_next;
    logic [10:0] cnt_reg, cnt_next;
    logic [17:0] off_reg, off_next;
    logic        zero_reg, zero_next;
    logic        sdone_reg, sdone_next;
    logic [1:0]  sstat_reg, sstat_next;
    logic        efin_reg, efin_next;
    logic [5:0]  fill_reg, fill_next;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]  wdata, rdata;
    refpd_pkg::chunk_ctl_t ctl;
    logic        free;

    logic [7:0]  b0;
    logic [2:0]  need;
    logic [3:0]  sz;
    logic [6:0]  lit;
    logic        lit_put, fin_cmd, done;
    logic [1:0]  status;
    logic [10:0] cp_len, total, produce;
    logic [31:0] avail, src;
    logic        lit_prod;

    refpd_hist_ram #(.AW(AW)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
    );

    refpd_chunker #(.CHUNK(CHUNK)) u_chunk (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .free(free),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= refpd_pkg::S_IN;
            phase_reg <= refpd_pkg::PH_FLAGS;
            hflags_reg <= '0;
            hrem_reg <= '0;
            ci_reg <= '0;
            ll_reg <= '0;
            exp_reg <= '0;
            oc_reg <= '0;
            fin_reg <= 1'b0;
            pl_reg <= '0;
            po_reg <= '0;
            endp_reg <= 1'b0;
            cnt_reg <= '0;
            efin_reg <= 1'b0;
            fill_reg <= '0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            hflags_reg <= hflags_next;
            hrem_reg <= hrem_next;
            ci_reg <= ci_next;
            ll_reg <= ll_next;
            exp_reg <= exp_next;
            oc_reg <= oc_next;
            fin_reg <= fin_next;
            pl_reg <= pl_next;
            po_reg <= po_next;
            endp_reg <= endp_next;
            cnt_reg <= cnt_next;
            efin_reg <= efin_next;
            fill_reg <= fill_next;
        end
        cb0_reg <= cb0_next;
        cb1_reg <= cb1_next;
        cb2_reg <= cb2_next;
        litb_reg <= litb_next;
        off_reg <= off_next;
        zero_reg <= zero_next;
        sdone_reg <= sdone_next;
        sstat_reg <= sstat_next;
    end

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        hflags_next = hflags_reg;
        hrem_next = hrem_reg;
        cb0_next = cb0_reg;
        cb1_next = cb1_reg;
        cb2_next = cb2_reg;
        ci_next = ci_reg;
        ll_next = ll_reg;
        exp_next = exp_reg;
        oc_next = oc_reg;
        fin_next = fin_reg;
        pl_next = pl_reg;
        po_next = po_reg;
        endp_next = endp_reg;
        litb_next = litb_reg;
        cnt_next = cnt_reg;
        off_next = off_reg;
        zero_next = zero_reg;
        sdone_next = sdone_reg;
        sstat_next = sstat_reg;
        efin_next = efin_reg;
        fill_next = fill_reg;
        s_tready = 1'b0;
        we = 1'b0;
        waddr = oc_reg[AW-1:0];
        wdata = litb_reg;
        src = oc_reg - {14'd0, off_reg};
        raddr = src[AW-1:0];
        ctl = '0;
        ctl.last = efin_reg;
        ctl.done = sdone_reg;
        ctl.status = sstat_reg;
        ctl.push_byte = litb_reg;
        b0 = (ci_reg == 2'd0) ? s_tdata : cb0_reg;
        need = (b0 < 8'h80) ? 3'd2 : (b0 < 8'hC0) ? 3'd3 : (b0 < 8'hE0) ? 3'd4 : 3'd1;
        sz = hflags_reg[7] ? 4'd4 : 4'd3;
        lit = '0;
        lit_put = 1'b0;
        fin_cmd = 1'b0;
        done = 1'b0;
        status = refpd_pkg::ST_OK;
        cp_len = '0;
        avail = (oc_reg >= exp_reg) ? 32'd0 : exp_reg - oc_reg;
        total = '0;
        produce = '0;
        lit_prod = 1'b0;

        case (state_reg)
            refpd_pkg::S_IN: begin
                s_tready = 1'b1;
                if (s_tvalid && !fin_reg) begin
                    case (phase_reg)
                        refpd_pkg::PH_FLAGS: begin
                            hflags_next = s_tdata;
                            phase_next = refpd_pkg::PH_MAGIC;
                        end
                        refpd_pkg::PH_MAGIC: begin
                            if (s_tdata != refpd_pkg::MAGIC_BYTE) begin
                                done = 1'b1;
                                status = refpd_pkg::ST_BAD_MAGIC;
                            end else begin
                                hrem_next = hflags_reg[0] ? {sz[2:0], 1'b0} : sz;
                                exp_next = '0;
                                phase_next = refpd_pkg::PH_SIZE;
                            end
                        end
                        refpd_pkg::PH_SIZE: begin
                            if (hrem_reg <= sz) begin
                                exp_next = {exp_reg[23:0], s_tdata};
                            end
                            hrem_next = (hrem_reg != 4'd0) ? hrem_reg - 4'd1 : 4'd0;
                            if (hrem_next == 4'd0) begin
                                phase_next = refpd_pkg::PH_CMD;
                                ci_next = '0;
                            end
                        end
                        refpd_pkg::PH_CMD: begin
                            if ({1'b0, ci_reg} + 3'd1 < need) begin
                                case (ci_reg)
                                    2'd0: cb0_next = s_tdata;
                                    2'd1: cb1_next = s_tdata;
                                    default: cb2_next = s_tdata;
                                endcase
                                ci_next = ci_reg + 2'd1;
                            end else begin
                                if (b0 < 8'h80) begin
                                    lit = {5'd0, b0[1:0]};
                                    pl_next = {8'd0, b0[4:2]} + 11'd3;
                                    po_next = {8'd0, b0[6:5], s_tdata} + 18'd1;
                                end else if (b0 < 8'hC0) begin
                                    lit = {5'd0, cb1_reg[7:6]};
                                    pl_next = {5'd0, b0[5:0]} + 11'd4;
                                    po_next = {4'd0, cb1_reg[5:0], s_tdata} + 18'd1;
                                end else if (b0 < 8'hE0) begin
                                    lit = {5'd0, b0[1:0]};
                                    pl_next = {1'b0, b0[3:2], s_tdata} + 11'd5;
                                    po_next = {1'b0, b0[4], cb1_reg, cb2_reg} + 18'd1;
                                end else if (b0 < 8'hFC) begin
                                    lit = {b0[4:0], 2'b00} + 7'd4;
                                    pl_next = '0;
                                end else begin
                                    lit = {5'd0, b0[1:0]};
                                    pl_next = '0;
                                    endp_next = 1'b1;
                                end
                                ci_next = '0;
                                if (lit != 7'd0) begin
                                    ll_next = lit;
                                    phase_next = refpd_pkg::PH_LIT;
                                end else begin
                                    fin_cmd = 1'b1;
                                end
                            end
                        end
                        refpd_pkg::PH_LIT: begin
                            lit_put = 1'b1;
                            ll_next = (ll_reg != 7'd0) ? ll_reg - 7'd1 : 7'd0;
                            if (ll_next == 7'd0) begin
                                fin_cmd = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (fin_cmd) begin
                        cp_len = pl_next;
                        pl_next = '0;
                        phase_next = refpd_pkg::PH_CMD;
                        if (endp_next) begin
                            endp_next = 1'b0;
                            done = 1'b1;
                        end
                    end
                    if (!done && s_tlast) begin
                        done = 1'b1;
                        if (phase_next != refpd_pkg::PH_CMD || ci_next != 2'd0) begin
                            status = refpd_pkg::ST_TRUNC;
                        end
                    end
                    total = cp_len + {10'd0, lit_put};
                    produce = ({21'd0, total} > avail) ? avail[10:0] : total;
                    lit_prod = lit_put && (avail != 32'd0);
                    if (status == refpd_pkg::ST_OK && {21'd0, total} > avail) begin
                        status = refpd_pkg::ST_LIMIT;
                    end
                    if (done) begin
                        fin_next = 1'b1;
                        phase_next = refpd_pkg::PH_DONE;
                    end
                    litb_next = s_tdata;
                    cnt_next = produce - {10'd0, lit_prod};
                    off_next = po_next;
                    sdone_next = done;
                    sstat_next = status;
                    fill_next = '0;
                    efin_next = 1'b1;
                    if (lit_prod) begin
                        state_next = refpd_pkg::S_LIT;
                    end else if (cnt_next != 11'd0) begin
                        state_next = refpd_pkg::S_CPRD;
                    end else if (done || status != refpd_pkg::ST_OK) begin
                        state_next = refpd_pkg::S_EMIT;
                    end
                end
            end
            refpd_pkg::S_LIT: begin
                we = 1'b1;
                ctl.push = 1'b1;
                oc_next = oc_reg + 32'd1;
                fill_next = fill_reg + 6'd1;
                state_next = (cnt_reg != 11'd0) ? refpd_pkg::S_CPRD : refpd_pkg::S_EMIT;
            end
            refpd_pkg::S_CPRD: begin
                zero_next = (off_reg == 18'd0) || (oc_reg < {14'd0, off_reg});
                state_next = refpd_pkg::S_CPWR;
            end
            refpd_pkg::S_CPWR: begin
                we = 1'b1;
                wdata = zero_reg ? 8'd0 : rdata;
                ctl.push = 1'b1;
                ctl.push_byte = wdata;
                oc_next = oc_reg + 32'd1;
                cnt_next = cnt_reg - 11'd1;
                fill_next = fill_reg + 6'd1;
                if (cnt_next == 11'd0) begin
                    efin_next = 1'b1;
                    state_next = refpd_pkg::S_EMIT;
                end else if (fill_next == 6'(CHUNK)) begin
                    efin_next = 1'b0;
                    state_next = refpd_pkg::S_EMIT;
                end else begin
                    state_next = refpd_pkg::S_CPRD;
                end
            end
            refpd_pkg::S_EMIT: begin
                if (free) begin
                    ctl.emit = 1'b1;
                    fill_next = '0;
                    state_next = efin_reg ? refpd_pkg::S_IN : refpd_pkg::S_CPRD;
                end
            end
            default: begin
                state_next = refpd_pkg::S_IN;
            end
        endcase
    end

    `RPD_ASSERT_NXT(a_read_then_write, state_reg == refpd_pkg::S_CPRD,
                    state_reg == refpd_pkg::S_CPWR)
    `RPD_ASSERT_IMP(a_final_done, m_tvalid && m_tlast && m_tuser[0], fin_reg)
    `RPD_ASSERT_IMP(a_chunk_size, m_tvalid, m_tdata[261:256] <= 6'(CHUNK))
    `RPD_ASSERT_IMP(a_out_limit, state_reg == refpd_pkg::S_IN, oc_reg <= exp_reg)
endmodule
`default_nettype wire

FILE: bench/refpack_decompressor_tb.sv
`default_nettype none
module refpack_decompressor_tb;
    localparam int HIST_DEPTH = refpd_pkg::WINDOW_SIZE_DEF;
    localparam int HIST_AW = $clog2(HIST_DEPTH);
    localparam int CHUNK_LEN = refpd_pkg::CHUNK_BYTES_DEF;
    localparam logic [7:0] OP_MEDIUM = 8'h80;
    localparam logic [7:0] OP_LARGE = 8'hC0;
    localparam logic [7:0] OP_LITRUN = 8'hE0;
    localparam logic [7:0] OP_EOS = 8'hFC;
    localparam logic [7:0] FLAG_SIZE4 = 8'h80;
    localparam logic [7:0] FLAG_CSIZE = 8'h01;

    typedef struct packed {
        logic [255:0] data;
        logic [5:0]   cnt;
        logic         lst;
        logic         done;
        logic [1:0]   st;
    } chunk_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [263:0] m_tdata;
    logic         m_tlast;
    logic [2:0]   m_tuser;

    refpack_decompressor u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    chunk_t chunk_q[$];
    int     errors = 0;
    int     bytes_sent = 0;
    int     send_idle = 0;
    int     recv_idle = 0;

    refpd_pkg::phase_t ph = refpd_pkg::PH_FLAGS;
    logic [7:0]  hflags = '0;
    int          hrem = 0;
    logic [7:0]  cmd [0:2];
    int          cidx = 0;
    int          lits_left = 0;
    logic [31:0] exp_size = '0;
    logic [31:0] out_cnt = '0;
    logic        fin = 1'b0;
    logic [7:0]  hist [0:HIST_DEPTH-1];
    int          pend_len = 0;
    logic [31:0] pend_off = '0;
    logic        end_pend = 1'b0;
    logic [7:0]  step_bytes[$];
    logic        dropped;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [255:0] got,
                                   input logic [255:0] want);
        $display("mismatch %s at %0t: got %h want %h", what, $time, got, want);
        errors++;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        if (out_cnt >= exp_size) begin
            dropped = 1'b1;
        end else begin
            hist[HIST_AW'(out_cnt % HIST_DEPTH)] = b;
            out_cnt++;
            step_bytes.push_back(b);
        end
    endtask

    task automatic replay_copy(input int len, input logic [31:0] off);
        logic [7:0] v;
        for (int i = 0; i < len; i++) begin
            if (out_cnt >= exp_size) begin
                dropped = 1'b1;
                return;
            end
            v = 8'h00;
            if (off != 0 && out_cnt >= off) v = hist[HIST_AW'((out_cnt - off) % HIST_DEPTH)];
            emit_byte(v);
        end
    endtask

    task automatic close_command(output logic ended);
        replay_copy(pend_len, pend_off);
        pend_len = 0;
        ph = refpd_pkg::PH_CMD;
        ended = end_pend;
        end_pend = 1'b0;
    endtask

    // Works out the chunks that one accepted stream byte produces.
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic       done;
        logic [1:0] st;
        logic [7:0] b0;
        int         need;
        int         lit;
        int         sz;
        int         nres;
        int         n;
        chunk_t     c;
        if (fin) return;
        step_bytes.delete();
        dropped = 1'b0;
        done = 1'b0;
        st = refpd_pkg::ST_OK;
        sz = hflags[7] ? 4 : 3;
        case (ph)
            refpd_pkg::PH_FLAGS: begin
                hflags = b;
                ph = refpd_pkg::PH_MAGIC;
            end
            refpd_pkg::PH_MAGIC: begin
                if (b != refpd_pkg::MAGIC_BYTE) begin
                    done = 1'b1;
                    st = refpd_pkg::ST_BAD_MAGIC;
                end else begin
                    hrem = hflags[0] ? 2 * sz : sz;
                    exp_size = '0;
                    ph = refpd_pkg::PH_SIZE;
                end
            end
            refpd_pkg::PH_SIZE: begin
                if (hrem <= sz) exp_size = {exp_size[23:0], b};
                if (hrem > 0) hrem--;
                if (hrem == 0) begin
                    ph = refpd_pkg::PH_CMD;
                    cidx = 0;
                end
            end
            refpd_pkg::PH_CMD: begin
                b0 = (cidx == 0) ? b : cmd[0];
                need = (b0 < OP_MEDIUM) ? 2 : (b0 < OP_LARGE) ? 3 : (b0 < OP_LITRUN) ? 4 : 1;
                if (cidx + 1 < need) begin
                    cmd[2'(cidx)] = b;
                    cidx++;
                end else begin
                    if (b0 < OP_MEDIUM) begin
                        lit = int'(b0[1:0]);
                        pend_len = b0[4:2] + 3;
                        pend_off = {b0[6:5], 8'h00} + b + 1;
                    end else if (b0 < OP_LARGE) begin
                        lit = int'(cmd[1][7:6]);
                        pend_len = b0[5:0] + 4;
                        pend_off = {cmd[1][5:0], 8'h00} + b + 1;
                    end else if (b0 < OP_LITRUN) begin
                        lit = int'(b0[1:0]);
                        pend_len = {b0[3:2], 8'h00} + b + 5;
                        pend_off = {b0[4], cmd[1], cmd[2]} + 1;
                    end else if (b0 < OP_EOS) begin
                        lit = {b0[4:0], 2'b00} + 4;
                        pend_len = 0;
                    end else begin
                        lit = int'(b0[1:0]);
                        pend_len = 0;
                        end_pend = 1'b1;
                    end
                    cidx = 0;
                    if (lit > 0) begin
                        lits_left = lit;
                        ph = refpd_pkg::PH_LIT;
                    end else begin
                        close_command(done);
                    end
                end
            end
            refpd_pkg::PH_LIT: begin
                emit_byte(b);
                if (lits_left > 0) lits_left--;
                if (lits_left == 0) close_command(done);
            end
            default: ;
        endcase
        if (!done && last) begin
            done = 1'b1;
            if (ph != refpd_pkg::PH_CMD || cidx != 0) st = refpd_pkg::ST_TRUNC;
        end
        if (st == refpd_pkg::ST_OK && dropped) st = refpd_pkg::ST_LIMIT;
        if (done) begin
            fin = 1'b1;
            ph = refpd_pkg::PH_DONE;
        end
        nres = (step_bytes.size() + CHUNK_LEN - 1) / CHUNK_LEN;
        if (nres == 0 && (dropped || done || st != refpd_pkg::ST_OK)) nres = 1;
        for (int k = 0; k < nres; k++) begin
            n = step_bytes.size() - k * CHUNK_LEN;
            if (n > CHUNK_LEN) n = CHUNK_LEN;
            if (n < 0) n = 0;
            c = '0;
            for (int i = 0; i < n; i++) c.data[i*8 +: 8] = step_bytes[k * CHUNK_LEN + i];
            c.cnt = 6'(n);
            c.lst = (k + 1 == nres);
            c.done = done;
            c.st = st;
            chunk_q.push_back(c);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last = 1'b0);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        decode_byte(b, last);
        bytes_sent++;
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        chunk_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (chunk_q.size() == 0) begin
                report_mismatch("unexpected transfer", m_tdata[255:0], '0);
            end else begin
                want = chunk_q.pop_front();
                if (m_tdata[255:0] !== want.data) report_mismatch("data", m_tdata[255:0], want.data);
                if (m_tdata[261:256] !== want.cnt) begin
                    report_mismatch("count", 256'(m_tdata[261:256]), 256'(want.cnt));
                end
                if (m_tlast !== want.lst) report_mismatch("tlast", 256'(m_tlast), 256'(want.lst));
                if (m_tuser[0] !== want.done) begin
                    report_mismatch("done", 256'(m_tuser[0]), 256'(want.done));
                end
                if (m_tuser[2:1] !== want.st) begin
                    report_mismatch("status", 256'(m_tuser[2:1]), 256'(want.st));
                end
            end
        end
    end

    task automatic send_literals(input int n);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(255)));
    endtask

    task automatic test_header();
        logic [31:0] size;
        size = $urandom_range(9000, 6000);
        send_byte(FLAG_SIZE4 | FLAG_CSIZE);
        send_byte(refpd_pkg::MAGIC_BYTE);
        send_byte(8'hFF); send_byte(8'h00); send_byte(8'hA5); send_byte(8'h5A);
        send_byte(size[31:24]); send_byte(size[23:16]); send_byte(size[15:8]);
        send_byte(size[7:0]);
    endtask

    task automatic test_commands();
        // The first copy reaches before the start of the output and yields zeros.
        send_byte(8'h7F); send_byte(8'hFF);
        send_byte(8'h00); send_byte(8'hFF); send_byte(8'hA5);
        send_byte(8'hBF); send_byte(8'hC0); send_byte(8'h02); send_literals(3);
        send_byte(OP_LARGE); send_byte(8'h00); send_byte(8'h00); send_byte(8'h00);
        send_byte(8'hDF); send_byte(8'h00); send_byte(8'h00); send_byte(8'hFF);
        send_literals(3);
        send_byte(OP_LITRUN); send_literals(4);
        send_byte(8'h00); send_byte(8'h00);
    endtask

    task automatic random_command();
        logic [7:0] b0;
        int         kind;
        kind = $urandom_range(9);
        if (kind < 3) begin
            b0 = 8'($urandom_range(8'h7F));
            send_byte(b0); send_byte(8'($urandom_range(255))); send_literals(int'(b0[1:0]));
        end else if (kind < 5) begin
            b0 = 8'($urandom_range(8'hBF, OP_MEDIUM));
            send_byte(b0);
            b0 = {2'($urandom_range(3)),
                  $urandom_range(3) == 0 ? 6'($urandom_range(63)) : 6'h00};
            send_byte(b0); send_byte(8'($urandom_range(255))); send_literals(int'(b0[7:6]));
        end else if (kind < 7) begin
            b0 = 8'($urandom_range(8'hDF, OP_LARGE));
            if ($urandom_range(7) != 0) b0[3:2] = 2'b00;
            if ($urandom_range(3) != 0) b0[4] = 1'b0;
            send_byte(b0);
            send_byte($urandom_range(3) == 0 ? 8'($urandom_range(255)) : 8'h00);
            send_byte(8'($urandom_range(255))); send_byte(8'($urandom_range(255)));
            send_literals(int'(b0[1:0]));
        end else if (kind < 9) begin
            b0 = $urandom_range(7) == 0 ? 8'($urandom_range(8'hFB, OP_LITRUN))
                                        : 8'($urandom_range(8'hE3, OP_LITRUN));
            send_byte(b0); send_literals({b0[4:0], 2'b00} + 4);
        end else begin
            send_literals(0);
            b0 = 8'($urandom_range(8'h7F));
            send_byte(b0); send_byte(8'($urandom_range(255))); send_literals(int'(b0[1:0]));
        end
    endtask

    task automatic test_random(input int goal);
        while (bytes_sent < goal) random_command();
    endtask

    task automatic test_output_limit();
        // Long copies until the declared size is reached, then one more to drop bytes.
        while (out_cnt < exp_size) begin
            send_byte(8'hCC); send_byte(8'h00); send_byte(8'h0F); send_byte(8'hFF);
        end
        send_byte(8'h00); send_byte(8'h00);
    endtask

    task automatic test_stream_end();
        logic [7:0] b0;
        case ($urandom_range(2))
            0: begin
                b0 = 8'($urandom_range(8'hFF, OP_EOS));
                send_byte(b0, b0[1:0] == 0);
                for (int i = 0; i < b0[1:0]; i++) begin
                    send_byte(8'($urandom_range(255)), i == b0[1:0] - 1);
                end
            end
            1: begin
                send_byte(8'h03); send_byte(8'h00); send_byte(8'h11); send_byte(8'h22);
                send_byte(8'h33, 1'b1);
            end
            default: begin
                send_byte(OP_LARGE); send_byte(8'h00, 1'b1);
            end
        endcase
        send_literals(3);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        send_idle = 23;
        recv_idle = 60;
        test_header();
        test_commands();
        test_random(120);
        send_idle = 60;
        recv_idle = 23;
        test_random(210);
        send_idle = 0;
        recv_idle = 0;
        test_random(280);
        test_output_limit();
        test_stream_end();
        while (chunk_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/refpd_pkg.sv
sv/refpd_hist_ram.sv
sv/refpd_chunker.sv
sv/refpack_decompressor.sv
bench/refpack_decompressor_tb.sv
